/* rtl/dcf_pkg.sv */
// Shared constants, widths and pipeline side-band types for the distance constraint force block.
`default_nettype none
package dcf_pkg;

  localparam int ID_W      = 10;
  localparam int POS_W     = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'd1;

  localparam logic [CFG_W-1:0] STRENGTH_RESET  = 32'h0001_0000;
  localparam logic [CFG_W-1:0] TOLERANCE_RESET = 32'h0000_0000;

  // Datapath widths
  localparam int MAG_W  = POS_W + 1;       // |B - A| per axis
  localparam int SUM_W  = 2 * MAG_W;       // sum of three squares
  localparam int RAD_W  = SUM_W + 2;       // radicand padded to even width
  localparam int ROOT_W = RAD_W / 2;       // distance
  localparam int REM_W  = ROOT_W + 2;      // square root remainder
  localparam int DIFF_W = ROOT_W + 1;      // signed dist - rest
  localparam int DEV_W  = ROOT_W;          // |diff|
  localparam int QUO_W  = 31;              // unit vector magnitude, Q1.30
  localparam int DREM_W = ROOT_W;          // divider remainder
  localparam int GAIN_SHIFT = 17;
  localparam int G_W    = DEV_W + CFG_W - GAIN_SHIFT;
  localparam int G_LO_W = 32;
  localparam int G_HI_W = G_W - G_LO_W;
  localparam int PL_W   = QUO_W + G_LO_W;
  localparam int PH_W   = QUO_W + G_HI_W;
  localparam int UNIT_SHIFT = 30;
  localparam int M_W    = PH_W + 3;

  typedef logic [MAG_W-1:0] mag_t;

  // Side-band that rides along the square root pipeline
  typedef struct packed {
    logic                  valid;
    logic [ID_W-1:0]       va;
    logic [ID_W-1:0]       vb;
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            dneg;
    logic [POS_W-1:0]      rest;
  } sq_side_t;

  // Side-band that rides along the divider pipeline
  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  va;
    logic [ID_W-1:0]  vb;
    logic [2:0]       neg;
    logic             apply;
    logic [DEV_W-1:0] dev;
    logic [G_W-1:0]   g;
  } div_side_t;

endpackage
`default_nettype wire

/* rtl/dcf_if.sv */
// Valid/ready channel interfaces for constraint transactions and force results.
`default_nettype none
interface dcf_in_if;
  logic                            valid;
  logic                            ready;
  logic [dcf_pkg::ID_W-1:0]        vertex_a;
  logic [dcf_pkg::ID_W-1:0]        vertex_b;
  logic signed [dcf_pkg::POS_W-1:0] pos_a_x;
  logic signed [dcf_pkg::POS_W-1:0] pos_a_y;
  logic signed [dcf_pkg::POS_W-1:0] pos_a_z;
  logic signed [dcf_pkg::POS_W-1:0] pos_b_x;
  logic signed [dcf_pkg::POS_W-1:0] pos_b_y;
  logic signed [dcf_pkg::POS_W-1:0] pos_b_z;
  logic [dcf_pkg::POS_W-1:0]       rest_length;

  modport source (output valid, vertex_a, vertex_b, pos_a_x, pos_a_y, pos_a_z,
                  pos_b_x, pos_b_y, pos_b_z, rest_length, input ready);
  modport sink (input valid, vertex_a, vertex_b, pos_a_x, pos_a_y, pos_a_z,
                pos_b_x, pos_b_y, pos_b_z, rest_length, output ready);
endinterface

interface dcf_out_if;
  logic                            valid;
  logic                            ready;
  logic [dcf_pkg::ID_W-1:0]        out_vertex_a;
  logic [dcf_pkg::ID_W-1:0]        out_vertex_b;
  logic signed [dcf_pkg::POS_W-1:0] force_x;
  logic signed [dcf_pkg::POS_W-1:0] force_y;
  logic signed [dcf_pkg::POS_W-1:0] force_z;
  logic [dcf_pkg::POS_W-1:0]       deviation;
  logic                            over_tolerance;

  modport source (output valid, out_vertex_a, out_vertex_b, force_x, force_y, force_z,
                  deviation, over_tolerance, input ready);
  modport sink (input valid, out_vertex_a, out_vertex_b, force_x, force_y, force_z,
                deviation, over_tolerance, output ready);
endinterface
`default_nettype wire

/* rtl/dcf_sqrt.sv */
// Pipelined integer square root, one result bit per stage, with side-band.
`default_nettype none
module dcf_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic [dcf_pkg::SUM_W-1:0]     rad_in,
  input  wire dcf_pkg::sq_side_t             side_in,
  output logic      [dcf_pkg::ROOT_W-1:0]    root_out,
  output dcf_pkg::sq_side_t                  side_out
);

  localparam int N = dcf_pkg::ROOT_W;

  logic [dcf_pkg::RAD_W-1:0]  rad  [0:N];
  logic [dcf_pkg::REM_W-1:0]  rem  [0:N];
  logic [dcf_pkg::ROOT_W-1:0] root [0:N];
  dcf_pkg::sq_side_t          side [0:N];

  assign rad[0]  = {2'b00, rad_in};
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = side_in;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [dcf_pkg::REM_W-1:0] trem;
    logic [dcf_pkg::REM_W-1:0] trial;
    logic                      ge;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
      trem  = {rem[k][dcf_pkg::REM_W-3:0], rad[k][dcf_pkg::RAD_W-1 -: 2]};
      trial = {root[k], 2'b01};
      ge    = (trem >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side[k+1].valid <= 1'b0;
      end else if (en) begin
        side[k+1] <= side[k];
      end
      if (en) begin
        rad[k+1]  <= {rad[k][dcf_pkg::RAD_W-3:0], 2'b00};
        rem[k+1]  <= ge ? (trem - trial) : trem;
        root[k+1] <= {root[k][dcf_pkg::ROOT_W-2:0], ge};
      end
    end
  end

  assign root_out = root[N];
  assign side_out = side[N];

endmodule
`default_nettype wire

/* rtl/dcf_div.sv */
// Three-lane pipelined restoring divider for the unit vector, one quotient bit per stage.
`default_nettype none
module dcf_div (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire logic [2:0][dcf_pkg::MAG_W-1:0]     mag_in,
  input  wire logic [dcf_pkg::ROOT_W-1:0]         dist_in,
  input  wire dcf_pkg::div_side_t                 side_in,
  output logic      [2:0][dcf_pkg::QUO_W-1:0]     quo_out,
  output dcf_pkg::div_side_t                      side_out
);

  localparam int N = dcf_pkg::QUO_W;

  logic [2:0][dcf_pkg::DREM_W-1:0] rem  [0:N];
  logic [2:0][dcf_pkg::QUO_W-1:0]  nb   [0:N];
  logic [2:0][dcf_pkg::QUO_W-1:0]  quo  [0:N];
  logic [dcf_pkg::ROOT_W-1:0]      dvsr [0:N];
  dcf_pkg::div_side_t              side [0:N];

  // Numerator is mag << 30; its upper part (mag >> 1) is already below the divisor
  for (genvar l = 0; l < 3; l++) begin : g_init
    assign rem[0][l] = dcf_pkg::DREM_W'(mag_in[l][dcf_pkg::MAG_W-1:1]);
    assign nb[0][l]  = {mag_in[l][0], {(dcf_pkg::QUO_W-1){1'b0}}};
    assign quo[0][l] = '0;
  end
  assign dvsr[0] = dist_in;
  assign side[0] = side_in;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [2:0][dcf_pkg::DREM_W:0]   trem;
    logic [2:0]                      ge;
    logic [2:0][dcf_pkg::DREM_W-1:0] rem_next;

    // Shift in one numerator bit per lane and subtract when it fits
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        trem[l]     = {rem[k][l], nb[k][l][dcf_pkg::QUO_W-1]};
        ge[l]       = (trem[l] >= {1'b0, dvsr[k]});
        rem_next[l] = ge[l] ? dcf_pkg::DREM_W'(trem[l] - {1'b0, dvsr[k]})
                            : dcf_pkg::DREM_W'(trem[l]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side[k+1].valid <= 1'b0;
      end else if (en) begin
        side[k+1] <= side[k];
      end
      if (en) begin
        dvsr[k+1] <= dvsr[k];
        for (int l = 0; l < 3; l++) begin
          rem[k+1][l] <= rem_next[l];
          nb[k+1][l]  <= {nb[k][l][dcf_pkg::QUO_W-2:0], 1'b0};
          quo[k+1][l] <= {quo[k][l][dcf_pkg::QUO_W-2:0], ge[l]};
        end
      end
    end
  end

  assign quo_out  = quo[N];
  assign side_out = side[N];

endmodule
`default_nettype wire

/* rtl/distance_constraint_force.sv */
// Top level of the distance constraint force pipeline.
//
// A constraint transaction on "pair" carries two vertex ids, two signed Q16.16
// positions and a rest length. Each one yields exactly one result transaction on
// "result": the force on vertex A (vertex B takes its negation), the length
// deviation, an over-tolerance flag and both ids, in input order.
// strength and tolerance are written through wr_en/wr_index/wr_data; write them
// only while no transaction is in flight.
// Throughput: one transaction per cycle unless the receiver stalls. The 34-stage
// square root (one root bit per stage) and the 31-stage three-lane divider (one
// quotient bit per stage) set the pipeline depth; the rest is one stage each for
// the difference, squares, sum, tolerance test, gain, partial products and the
// output register.
// When the receiver stalls the whole pipeline holds in place; pair.ready is low
// only while a result waits in the output register and result.ready is low.
// Reset (rst, synchronous) empties the pipeline and restores strength to 1.0
// and tolerance to 0.
`default_nettype none
module distance_constraint_force (
  input  wire logic                            clk,
  input  wire logic                            rst,
  dcf_in_if.sink                               pair,
  dcf_out_if.source                            result,
  input  wire logic                            wr_en,
  input  wire logic [dcf_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire logic [dcf_pkg::CFG_W-1:0]       wr_data
);

  logic [dcf_pkg::CFG_W-1:0] strength;
  logic [dcf_pkg::CFG_W-1:0] tolerance;
  logic                      en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strength  <= dcf_pkg::STRENGTH_RESET;
      tolerance <= dcf_pkg::TOLERANCE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        dcf_pkg::REG_STRENGTH:  strength  <= wr_data;
        dcf_pkg::REG_TOLERANCE: tolerance <= wr_data;
        default: ;
      endcase
    end
  end

  // Advance everything unless the output holds a result that is not taken
  assign en         = !result.valid || result.ready;
  assign pair.ready = en;

  // Stage 1: per-axis difference, magnitude and sign
  logic signed [dcf_pkg::MAG_W-1:0] d [0:2];
  dcf_pkg::sq_side_t                s1_side;

  always_comb begin
    d[0] = {pair.pos_b_x[dcf_pkg::POS_W-1], pair.pos_b_x}
         - {pair.pos_a_x[dcf_pkg::POS_W-1], pair.pos_a_x};
    d[1] = {pair.pos_b_y[dcf_pkg::POS_W-1], pair.pos_b_y}
         - {pair.pos_a_y[dcf_pkg::POS_W-1], pair.pos_a_y};
    d[2] = {pair.pos_b_z[dcf_pkg::POS_W-1], pair.pos_b_z}
         - {pair.pos_a_z[dcf_pkg::POS_W-1], pair.pos_a_z};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_side.valid <= 1'b0;
    end else if (en) begin
      s1_side.valid <= pair.valid;
    end
    if (en) begin
      s1_side.va   <= pair.vertex_a;
      s1_side.vb   <= pair.vertex_b;
      s1_side.rest <= pair.rest_length;
      for (int i = 0; i < 3; i++) begin
        s1_side.dneg[i] <= d[i][dcf_pkg::MAG_W-1];
        s1_side.mag[i]  <= d[i][dcf_pkg::MAG_W-1] ? dcf_pkg::mag_t'(-d[i])
                                                  : dcf_pkg::mag_t'(d[i]);
      end
    end
  end

  // Stage 2: squares
  logic [dcf_pkg::SUM_W-1:0] s2_sq [0:2];
  dcf_pkg::sq_side_t         s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_side.valid <= 1'b0;
    end else if (en) begin
      s2_side <= s1_side;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_sq[i] <= dcf_pkg::SUM_W'(s1_side.mag[i]) * dcf_pkg::SUM_W'(s1_side.mag[i]);
      end
    end
  end

  // Stage 3: sum of squares
  logic [dcf_pkg::SUM_W-1:0] s3_sum;
  dcf_pkg::sq_side_t         s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_side.valid <= 1'b0;
    end else if (en) begin
      s3_side <= s2_side;
    end
    if (en) begin
      s3_sum <= s2_sq[0] + s2_sq[1] + s2_sq[2];
    end
  end

  // Distance
  logic [dcf_pkg::ROOT_W-1:0] len;
  dcf_pkg::sq_side_t          sq_side;

  dcf_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .rad_in   (s3_sum),
    .side_in  (s3_side),
    .root_out (len),
    .side_out (sq_side)
  );

  // Length error, tolerance test and direction signs
  logic [dcf_pkg::DIFF_W-1:0] diff;
  logic [dcf_pkg::DEV_W-1:0]  dev_c;

  always_comb begin
    diff  = {1'b0, len} - dcf_pkg::DIFF_W'(sq_side.rest);
    dev_c = diff[dcf_pkg::DIFF_W-1] ? dcf_pkg::DEV_W'(-diff) : dcf_pkg::DEV_W'(diff);
  end

  dcf_pkg::sq_side_t          e_side;
  logic [dcf_pkg::ROOT_W-1:0] e_dist;
  logic [dcf_pkg::DEV_W-1:0]  e_dev;
  logic                       e_apply;
  logic [2:0]                 e_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_side.valid <= 1'b0;
    end else if (en) begin
      e_side <= sq_side;
    end
    if (en) begin
      e_dist  <= len;
      e_dev   <= dev_c;
      e_apply <= (dev_c > dcf_pkg::DEV_W'(tolerance)) && (len != '0);
      for (int i = 0; i < 3; i++) begin
        e_neg[i] <= sq_side.dneg[i] ^ diff[dcf_pkg::DIFF_W-1];
      end
    end
  end

  // Gain: deviation * strength * 0.5
  logic [dcf_pkg::DEV_W+dcf_pkg::CFG_W-1:0] gprod;
  dcf_pkg::div_side_t                       g_side;
  logic [2:0][dcf_pkg::MAG_W-1:0]           g_mag;
  logic [dcf_pkg::ROOT_W-1:0]               g_dist;

  assign gprod = (dcf_pkg::DEV_W+dcf_pkg::CFG_W)'(e_dev)
               * (dcf_pkg::DEV_W+dcf_pkg::CFG_W)'(strength);

  always_ff @(posedge clk) begin
    if (rst) begin
      g_side.valid <= 1'b0;
    end else if (en) begin
      g_side.valid <= e_side.valid;
    end
    if (en) begin
      g_side.va    <= e_side.va;
      g_side.vb    <= e_side.vb;
      g_side.neg   <= e_neg;
      g_side.apply <= e_apply;
      g_side.dev   <= e_dev;
      g_side.g     <= gprod[dcf_pkg::DEV_W+dcf_pkg::CFG_W-1:dcf_pkg::GAIN_SHIFT];
      g_mag        <= e_side.mag;
      g_dist       <= e_dist;
    end
  end

  // Unit vector magnitudes
  logic [2:0][dcf_pkg::QUO_W-1:0] quo;
  dcf_pkg::div_side_t             dv_side;

  dcf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .mag_in   (g_mag),
    .dist_in  (g_dist),
    .side_in  (g_side),
    .quo_out  (quo),
    .side_out (dv_side)
  );

  // Partial products of unit * gain
  logic [dcf_pkg::PL_W-1:0] p_lo [0:2];
  logic [dcf_pkg::PH_W-1:0] p_hi [0:2];
  dcf_pkg::div_side_t       p_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_side.valid <= 1'b0;
    end else if (en) begin
      p_side <= dv_side;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_lo[i] <= dcf_pkg::PL_W'(quo[i])
                 * dcf_pkg::PL_W'(dv_side.g[dcf_pkg::G_LO_W-1:0]);
        p_hi[i] <= dcf_pkg::PH_W'(quo[i])
                 * dcf_pkg::PH_W'(dv_side.g[dcf_pkg::G_W-1:dcf_pkg::G_LO_W]);
      end
    end
  end

  // Combine, shift down by 30 and saturate
  function automatic logic [dcf_pkg::POS_W-1:0] sat_force(
    input logic [dcf_pkg::M_W-1:0] m,
    input logic                    neg
  );
    logic [dcf_pkg::POS_W-1:0] r;
    if (neg) begin
      if (m >= dcf_pkg::M_W'(33'h0_8000_0000)) r = 32'h8000_0000;
      else r = -m[dcf_pkg::POS_W-1:0];
    end else begin
      if (m > dcf_pkg::M_W'(33'h0_7FFF_FFFF)) r = 32'h7FFF_FFFF;
      else r = m[dcf_pkg::POS_W-1:0];
    end
    return r;
  endfunction

  logic [dcf_pkg::M_W-1:0]   mval [0:2];
  logic [dcf_pkg::POS_W-1:0] fval [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mval[i] = dcf_pkg::M_W'({p_hi[i], 2'b00})
              + dcf_pkg::M_W'(p_lo[i][dcf_pkg::PL_W-1:dcf_pkg::UNIT_SHIFT]);
      fval[i] = p_side.apply ? sat_force(mval[i], p_side.neg[i]) : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= p_side.valid;
    end
    if (en) begin
      result.out_vertex_a   <= p_side.va;
      result.out_vertex_b   <= p_side.vb;
      result.force_x        <= fval[0];
      result.force_y        <= fval[1];
      result.force_z        <= fval[2];
      result.deviation      <= (|p_side.dev[dcf_pkg::DEV_W-1:dcf_pkg::POS_W])
                               ? {dcf_pkg::POS_W{1'b1}}
                               : p_side.dev[dcf_pkg::POS_W-1:0];
      result.over_tolerance <= p_side.apply;
    end
  end

endmodule
`default_nettype wire
